### sv/cssa_pkg.sv
package cssa_pkg;

  // Sizing of the store and of the set buffer.
  localparam int MAX_SETS  = 256;
  localparam int MAX_ORDER = 8;
  localparam int ID_WIDTH  = 16;

  // Field widths fixed by the interface.
  localparam int EVENT_W  = 16;
  localparam int STATUS_W = 2;
  localparam int ORDER_W  = 4;
  localparam int INDEX_W  = 8;
  localparam int OUT_W    = 16;

  // Derived internal widths.
  localparam int CNT_W = $clog2(MAX_SETS + 1);
  localparam int IDX_W = $clog2(MAX_SETS);
  localparam int LEN_W = $clog2(MAX_ORDER + 1);
  localparam int POS_W = $clog2(MAX_ORDER);
  localparam int ROW_W = MAX_ORDER * ID_WIDTH + LEN_W;

  // Request kinds carried in tuser.
  localparam logic MODE_EVENT = 1'b0;
  localparam logic MODE_CLEAR = 1'b1;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_KEPT     = 2'd0,
    ST_ABSORBED = 2'd1,
    ST_FULL     = 2'd2,
    ST_TOO_LONG = 2'd3
  } status_t;

endpackage

### sv/cssa_ram.sv
module cssa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one read port with registered read data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/cut_set_subset_absorber_unit.sv
// Minimal cut set absorber. Event identifiers of a cut set arrive one per request on the
// slave stream, tlast on the final one; tuser set means clear the store (no result). Each
// completed set gives one result: kept with its slot, absorbed by a stored smaller subset,
// minimal but store full, or too long. Elements are taken one per cycle while collecting;
// s_tready is low while a set is scanned and its result delivered. The store is one memory
// row per set, and the scan reads one row per cycle and tests it against the buffered set
// in parallel, stopping on the first absorbing row. A too-long set skips the scan. The store
// needs no clearing pass after reset; the set counter alone marks which rows are valid.
module cut_set_subset_absorber_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [cssa_pkg::EVENT_W-1:0]  s_tdata,  // event_id[15:0]
  input  logic                          s_tuser,  // mode[0]
  input  logic                          s_tlast,  // last_of_set
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [cssa_pkg::OUT_W-1:0]    m_tdata   // status[1:0], set_order[5:2],
                                                  // set_index[13:6], zero[15:14]
);
  import cssa_pkg::*;

  typedef enum logic [1:0] {
    S_COLLECT,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t                  state;
  logic [CNT_W-1:0]        stored_count;
  logic [LEN_W-1:0]        cur_len;
  logic                    too_long;
  logic [ID_WIDTH-1:0]     cur_ev [MAX_ORDER];
  logic [CNT_W-1:0]        scan_addr;
  logic                    rd_vld;
  logic                    absorbed;

  logic                    s_fire;
  logic [ID_WIDTH-1:0]     in_id;
  logic                    too_long_next;
  logic                    out_free;
  logic                    issue;
  logic                    ram_we;
  logic [ROW_W-1:0]        wr_row;
  logic [ROW_W-1:0]        rd_row;
  logic [LEN_W-1:0]        rd_order;
  logic                    subset;
  logic                    hit;
  status_t                 status_next;

  assign s_tready = (state == S_COLLECT);
  assign s_fire   = s_tvalid && s_tready;
  assign in_id    = ID_WIDTH'(s_tdata);
  assign out_free = !m_tvalid || m_tready;
  assign too_long_next = too_long || (cur_len == LEN_W'(MAX_ORDER));

  // Issue one row read per scan cycle while stored sets remain and no absorbing row is pending.
  assign issue = (state == S_SCAN) && !(rd_vld && hit) && (scan_addr < stored_count);

  // Pack the buffered set and its order into one store row.
  always_comb begin
    wr_row = '0;
    for (int k = 0; k < MAX_ORDER; k++) begin
      wr_row[k*ID_WIDTH +: ID_WIDTH] = cur_ev[k];
    end
    wr_row[ROW_W-1 -: LEN_W] = cur_len;
  end

  // Subset test of the row just read against the buffered set.
  assign rd_order = rd_row[ROW_W-1 -: LEN_W];
  always_comb begin
    logic member;
    subset = 1'b1;
    for (int k = 0; k < MAX_ORDER; k++) begin
      member = 1'b0;
      for (int i = 0; i < MAX_ORDER; i++) begin
        if ((LEN_W'(i) < cur_len) &&
            (cur_ev[i] == rd_row[k*ID_WIDTH +: ID_WIDTH])) begin
          member = 1'b1;
        end
      end
      if ((LEN_W'(k) < rd_order) && !member) begin
        subset = 1'b0;
      end
    end
  end
  assign hit = (rd_order < cur_len) && subset;

  // Outcome of a completed set.
  always_comb begin
    if (too_long) begin
      status_next = ST_TOO_LONG;
    end else if (absorbed) begin
      status_next = ST_ABSORBED;
    end else if (stored_count >= CNT_W'(MAX_SETS)) begin
      status_next = ST_FULL;
    end else begin
      status_next = ST_KEPT;
    end
  end

  assign ram_we = (state == S_FINISH) && out_free && (status_next == ST_KEPT);

  cssa_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_SETS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (stored_count[IDX_W-1:0]),
    .wdata (wr_row),
    .re    (issue),
    .raddr (scan_addr[IDX_W-1:0]),
    .rdata (rd_row)
  );

  // Buffered set elements; no reset needed.
  always_ff @(posedge clk) begin
    if (s_fire && (s_tuser == MODE_EVENT) && (cur_len < LEN_W'(MAX_ORDER))) begin
      cur_ev[cur_len[POS_W-1:0]] <= in_id;
    end
  end

  // Sequencer: collect, scan the store, then deliver the result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_COLLECT;
      stored_count <= '0;
      cur_len      <= '0;
      too_long     <= 1'b0;
      scan_addr    <= '0;
      rd_vld       <= 1'b0;
      absorbed     <= 1'b0;
      m_tvalid     <= 1'b0;
      m_tdata      <= '0;
    end else begin
      // A taken result is dropped unless a new one replaces it in the same cycle.
      if (m_tvalid && m_tready && !((state == S_FINISH) && out_free)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_COLLECT: begin
          if (s_fire) begin
            if (s_tuser == MODE_CLEAR) begin
              stored_count <= '0;
              cur_len      <= '0;
              too_long     <= 1'b0;
            end else begin
              if (cur_len < LEN_W'(MAX_ORDER)) begin
                cur_len <= cur_len + 1'b1;
              end
              too_long <= too_long_next;
              if (s_tlast) begin
                scan_addr <= '0;
                rd_vld    <= 1'b0;
                absorbed  <= 1'b0;
                state     <= too_long_next ? S_FINISH : S_SCAN;
              end
            end
          end
        end
        S_SCAN: begin
          if (rd_vld && hit) begin
            absorbed <= 1'b1;
            rd_vld   <= 1'b0;
            state    <= S_FINISH;
          end else if (issue) begin
            scan_addr <= scan_addr + 1'b1;
            rd_vld    <= 1'b1;
          end else begin
            rd_vld <= 1'b0;
            if (!rd_vld) begin
              state <= S_FINISH;
            end
          end
        end
        S_FINISH: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {2'b00,
                         (status_next == ST_KEPT) ? INDEX_W'(stored_count) : INDEX_W'(0),
                         ORDER_W'(cur_len),
                         status_next};
            if (status_next == ST_KEPT) begin
              stored_count <= stored_count + 1'b1;
            end
            cur_len  <= '0;
            too_long <= 1'b0;
            state    <= S_COLLECT;
          end
        end
        default: begin
          state <= S_COLLECT;
        end
      endcase
    end
  end

  // The store count never passes the number of rows.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stored_count <= CNT_W'(MAX_SETS))
    else $error("stored set count beyond store size");

  // A kept set advances the store count by exactly one.
  a_kept_count: assert property (@(posedge clk) disable iff (rst)
    ram_we |=> (stored_count == $past(stored_count) + 1'b1))
    else $error("kept set did not advance store count");

  // Read data is only pending during a scan.
  a_read_in_scan: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> (state == S_SCAN))
    else $error("row read pending outside scan");

  // The set buffer never holds more than its capacity.
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    cur_len <= LEN_W'(MAX_ORDER))
    else $error("set buffer length beyond capacity");

endmodule

### dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import cssa_pkg::*;

  // One request on the slave stream.
  typedef struct packed {
    logic               mode;
    logic [EVENT_W-1:0] event_id;
    logic               last;
  } request_t;

  // One result on the master stream.
  typedef struct packed {
    status_t            status;
    logic [ORDER_W-1:0] order;
    logic [INDEX_W-1:0] index;
  } verdict_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [EVENT_W-1:0] s_tdata = '0;
  logic               s_tuser = 1'b0;
  logic               s_tlast = 1'b0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [OUT_W-1:0]   m_tdata;

  cut_set_subset_absorber_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the cut set store and of the set being collected.
  logic [ID_WIDTH-1:0] kept_events [MAX_SETS][MAX_ORDER];
  int unsigned         kept_order [MAX_SETS];
  int unsigned         kept_count = 0;
  logic [ID_WIDTH-1:0] open_events [MAX_ORDER];
  int unsigned         open_len = 0;
  bit                  open_too_long = 1'b0;

  verdict_t    expected_verdicts [$];
  request_t    pending [$];
  int unsigned total_requests = 0;
  int unsigned accepted = 0;
  int unsigned bad_verdicts = 0;

  function automatic bit open_set_holds(logic [ID_WIDTH-1:0] id);
    for (int i = 0; i < open_len; i++) begin
      if (open_events[i] == id) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Apply one accepted request to the shadow store; a completed set queues its verdict.
  function automatic void absorb_request(request_t req);
    verdict_t v;
    bit       covered;
    if (req.mode == MODE_CLEAR) begin
      kept_count    = 0;
      open_len      = 0;
      open_too_long = 1'b0;
      return;
    end
    if (open_len < MAX_ORDER) begin
      open_events[open_len] = req.event_id[ID_WIDTH-1:0];
      open_len++;
    end else begin
      open_too_long = 1'b1;
    end
    if (!req.last) return;

    v.order = ORDER_W'(open_len);
    v.index = '0;
    if (open_too_long) begin
      v.status = ST_TOO_LONG;
    end else begin
      // Only stored sets of strictly smaller order can absorb the new one.
      covered = 1'b0;
      for (int s = 0; s < kept_count && !covered; s++) begin
        if (kept_order[s] < open_len) begin
          covered = 1'b1;
          for (int k = 0; k < kept_order[s]; k++) begin
            if (!open_set_holds(kept_events[s][k])) covered = 1'b0;
          end
        end
      end
      if (covered) begin
        v.status = ST_ABSORBED;
      end else if (kept_count >= MAX_SETS) begin
        v.status = ST_FULL;
      end else begin
        v.status = ST_KEPT;
        v.index  = INDEX_W'(kept_count);
        for (int k = 0; k < open_len; k++) kept_events[kept_count][k] = open_events[k];
        kept_order[kept_count] = open_len;
        kept_count++;
      end
    end
    open_len      = 0;
    open_too_long = 1'b0;
    expected_verdicts.push_back(v);
  endfunction

  function automatic void push_req(logic mode, logic [EVENT_W-1:0] id, logic last);
    request_t r;
    r.mode     = mode;
    r.event_id = id;
    r.last     = last;
    pending.push_back(r);
    total_requests++;
  endfunction

  function automatic void push_set(logic [EVENT_W-1:0] cut [$]);
    foreach (cut[i]) push_req(MODE_EVENT, cut[i], i == cut.size() - 1);
  endfunction

  // Sets of growing order drawn from a small pool so that absorption is frequent,
  // mixed with too-long sets, broken sets, noise and out-of-order sets.
  task automatic run_episode();
    logic [EVENT_W-1:0] pool [10];
    logic [EVENT_W-1:0] cut [$];
    bit                 taken [10];
    int unsigned        order, len, pick, kind;
    if ($urandom_range(0, 3) != 0) push_req(MODE_CLEAR, EVENT_W'($urandom), 1'($urandom));
    foreach (pool[i]) pool[i] = EVENT_W'($urandom);
    order = $urandom_range(1, 2);
    repeat ($urandom_range(3, 15)) begin
      kind = $urandom_range(0, 19);
      cut.delete();
      case (kind)
        0: begin
          repeat ($urandom_range(MAX_ORDER + 1, MAX_ORDER + 4)) cut.push_back(EVENT_W'($urandom));
        end
        1: begin
          // A set cut short by a clear.
          repeat ($urandom_range(1, 4)) push_req(MODE_EVENT, pool[$urandom_range(0, 9)], 1'b0);
          push_req(MODE_CLEAR, EVENT_W'($urandom), 1'($urandom));
        end
        2: begin
          repeat ($urandom_range(1, MAX_ORDER)) cut.push_back(EVENT_W'($urandom));
        end
        default: begin
          len = (kind == 3) ? $urandom_range(1, order) : order;
          foreach (taken[i]) taken[i] = 1'b0;
          repeat (len) begin
            do pick = $urandom_range(0, 9); while (taken[pick]);
            taken[pick] = 1'b1;
            cut.push_back(pool[pick]);
          end
          // Occasionally repeat an identifier within the set.
          if (kind == 4) cut[cut.size() - 1] = cut[0];
        end
      endcase
      if (cut.size() != 0) push_set(cut);
      if (order < MAX_ORDER && $urandom_range(0, 2) == 0) order++;
    end
  endtask

  // Fill every slot with singletons, then send pairs against the full store.
  task automatic fill_store();
    logic [EVENT_W-1:0] singles [$];
    logic [EVENT_W-1:0] cut [$];
    push_req(MODE_CLEAR, '0, 1'b0);
    repeat (MAX_SETS + $urandom_range(1, 6)) begin
      singles.push_back(EVENT_W'($urandom));
      push_req(MODE_EVENT, singles[$], 1'b1);
    end
    repeat (8) begin
      cut.delete();
      cut.push_back(EVENT_W'($urandom));
      if ($urandom_range(0, 1) == 0) cut.push_back(singles[$urandom_range(0, singles.size() - 1)]);
      else cut.push_back(EVENT_W'($urandom));
      push_set(cut);
    end
  endtask

  // Request driver: bursts of random length separated by random gaps.
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(posedge clk) begin : drive_requests
    request_t next_req;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (gap_left != 0 || pending.size() == 0) begin
        s_tvalid <= 1'b0;
        if (gap_left != 0) gap_left <= gap_left - 1;
      end else begin
        next_req = pending.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= next_req.event_id;
        s_tuser  <= next_req.mode;
        s_tlast  <= next_req.last;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // Result receiver: stalls follow a 32-bit pattern, indexed by a free-running tick, that changes every so often.
  logic [31:0] ready_pattern = '1;
  int unsigned pattern_left = 0;
  logic [4:0]  tick = '0;

  always @(posedge clk) begin
    tick     <= tick + 1'b1;
    m_tready <= rst ? 1'b0 : ready_pattern[tick];
    if (pattern_left == 0) begin
      pattern_left <= $urandom_range(20, 120);
      case ($urandom_range(0, 3))
        0:       ready_pattern <= '1;
        1:       ready_pattern <= $urandom | $urandom;
        2:       ready_pattern <= $urandom;
        default: ready_pattern <= $urandom & $urandom;
      endcase
    end else begin
      pattern_left <= pattern_left - 1;
    end
  end

  function automatic void note_mismatch(string what);
    bad_verdicts++;
    if (bad_verdicts <= 10) $display("%0t: %s", $realtime, what);
  endfunction

  // Monitor: predict on each accepted request, compare each accepted result.
  always @(posedge clk) begin : check_verdicts
    request_t seen;
    verdict_t want;
    logic [STATUS_W-1:0] got_status;
    logic [ORDER_W-1:0]  got_order;
    logic [INDEX_W-1:0]  got_index;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        seen.mode     = s_tuser;
        seen.event_id = s_tdata;
        seen.last     = s_tlast;
        absorb_request(seen);
        accepted++;
      end
      if (m_tvalid && m_tready) begin
        got_status = m_tdata[STATUS_W-1:0];
        got_order  = m_tdata[STATUS_W +: ORDER_W];
        got_index  = m_tdata[STATUS_W + ORDER_W +: INDEX_W];
        if (expected_verdicts.size() == 0) begin
          note_mismatch($sformatf("unexpected result status=%0d order=%0d index=%0d",
                                  got_status, got_order, got_index));
        end else begin
          want = expected_verdicts.pop_front();
          if (got_status !== want.status || got_order !== want.order ||
              got_index !== want.index) begin
            note_mismatch($sformatf(
              "result mismatch: expected status=%0d order=%0d index=%0d, got %0d/%0d/%0d",
              want.status, want.order, want.index, got_status, got_order, got_index));
          end
        end
      end
    end
  end

  initial begin : stimulus
    bit filled;
    filled = 1'b0;

    // Directed: absorption, extreme identifiers, too long, out of order,
    // repeated identifier, clear in the middle of a set.
    push_req(MODE_EVENT, 16'd1, 1'b1);
    push_req(MODE_EVENT, 16'd1, 1'b0);
    push_req(MODE_EVENT, 16'd2, 1'b1);
    push_req(MODE_EVENT, 16'd3, 1'b0);
    push_req(MODE_EVENT, 16'd4, 1'b1);
    push_req(MODE_EVENT, 16'd0, 1'b0);
    push_req(MODE_EVENT, 16'hFFFF, 1'b1);
    for (int i = 10; i < 19; i++) push_req(MODE_EVENT, EVENT_W'(i), i == 18);
    push_req(MODE_EVENT, 16'd5, 1'b1);
    push_req(MODE_EVENT, 16'd7, 1'b0);
    push_req(MODE_EVENT, 16'd7, 1'b1);
    push_req(MODE_EVENT, 16'd9, 1'b0);
    push_req(MODE_CLEAR, 16'hFFFF, 1'b1);
    push_req(MODE_EVENT, 16'd1, 1'b0);
    push_req(MODE_EVENT, 16'd2, 1'b1);
    push_req(MODE_EVENT, 16'd2, 1'b0);
    push_req(MODE_EVENT, 16'd1, 1'b0);
    push_req(MODE_EVENT, 16'd8, 1'b1);

    // Random episodes, one of which drives the store past full.
    while (total_requests < 1525) begin
      if (!filled && total_requests > 700) begin
        fill_store();
        filled = 1'b1;
      end else begin
        run_episode();
      end
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    wait (accepted == total_requests);
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (MAX_SETS + 64) @(posedge clk);

    if (bad_verdicts == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
